>>> rtl/core/prd_pkg.sv
// shared types and constants for the protection region decomposer
package prd_pkg;

	localparam int unsigned ADDR_W       = 64;
	localparam int unsigned ATTR_W       = 32;
	localparam int unsigned INDEX_W      = 4;
	localparam int unsigned COUNT_W      = 5;
	localparam int unsigned POW_W        = 7;
	localparam int unsigned CODE_W       = 6;
	localparam int unsigned SUBREGIONS   = 8;
	localparam int unsigned SUB_SHIFT    = 3;
	localparam int unsigned CFG_DATA_W   = 7;
	localparam int unsigned CFG_INDEX_W  = 1;

	localparam logic [COUNT_W-1:0] MAX_REGIONS        = 5'd16;
	localparam logic [POW_W-1:0]   MAX_POW            = 7'd64;
	localparam logic [POW_W-1:0]   SMALLEST_FAIL_POW  = 7'd15;
	localparam logic [POW_W-1:0]   RESET_ADDRESS_WIDTH = 7'd32;
	localparam logic [COUNT_W-1:0] RESET_REGION_COUNT = 5'd9;

	localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS_WIDTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_REGION_COUNT  = 1'b1;

	localparam logic [1:0] STATUS_OK             = 2'd0;
	localparam logic [1:0] STATUS_NOT_COVERABLE  = 2'd1;
	localparam logic [1:0] STATUS_OUT_OF_REGIONS = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0]  start_address;
		logic [ADDR_W-1:0]  length;
		logic [ATTR_W-1:0]  attributes;
		logic [INDEX_W-1:0] first_region;
	} request_t;

	typedef struct packed {
		logic [INDEX_W-1:0]    region_index;
		logic [ADDR_W-1:0]     base_address;
		logic [CODE_W-1:0]     size_code;
		logic [SUBREGIONS-1:0] subregion_disable;
		logic [ATTR_W-1:0]     attributes_out;
		logic                  entry_valid;
		logic [1:0]            status;
		logic [COUNT_W-1:0]    next_free_region;
		logic                  last;
	} result_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [ADDR_W-1:0]  len;
		logic [ADDR_W-1:0]  end_addr;
		logic [ATTR_W-1:0]  attr;
		logic [INDEX_W-1:0] first;
		logic [POW_W-1:0]   top;
		logic [COUNT_W-1:0] limit;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_APPLY,
		ST_ERR
	} back_state_t;

endpackage

>>> rtl/core/prd_front.sv
// front end: configuration registers and request classification into jobs
module prd_front
	import prd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  request_t               in_data,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   full,
	output logic                   push,
	output job_t                   job
);

	logic [POW_W-1:0]   address_width_q;
	logic [COUNT_W-1:0] region_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_width_q <= RESET_ADDRESS_WIDTH;
			region_count_q  <= RESET_REGION_COUNT;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ADDRESS_WIDTH: address_width_q <= cfg_data[POW_W-1:0];
				REG_REGION_COUNT:  region_count_q  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !full;
	assign push     = in_valid && !full;

	always_comb begin
		job.addr     = in_data.start_address;
		job.len      = in_data.length;
		// range end stays fixed while regions are carved off
		job.end_addr = in_data.start_address + in_data.length;
		job.attr     = in_data.attributes;
		job.first    = in_data.first_region;
		job.top      = (address_width_q > MAX_POW) ? MAX_POW : address_width_q;
		job.limit    = (region_count_q > MAX_REGIONS) ? MAX_REGIONS : region_count_q;
	end

endmodule

>>> rtl/core/prd_queue.sv
// small job queue between front and back
module prd_queue
	import prd_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output job_t pop_data
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == FULL_CNT);
	assign pop_valid = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/prd_back.sv
// back end: size search sequencer, region builder and output register
module prd_back
	import prd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_valid,
	input  job_t    job,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	localparam logic [ADDR_W-1:0] ONES = '1;

	back_state_t        state_q;
	back_state_t        state_d;
	logic [ADDR_W-1:0]  addr_q;
	logic [ADDR_W-1:0]  len_q;
	logic [ADDR_W-1:0]  end_q;
	logic [ATTR_W-1:0]  attr_q;
	logic [COUNT_W-1:0] reg_q;
	logic [POW_W-1:0]   top_q;
	logic [COUNT_W-1:0] limit_q;
	logic [POW_W-1:0]   pow_q;
	logic               whole_q;
	logic [2:0]         k_q;
	logic [3:0]         nen_q;
	logic [1:0]         status_q;
	logic               pend_valid_q;
	result_t            pend_q;
	logic               out_valid_q;
	result_t            out_q;

	logic               slot_free;
	logic [ADDR_W-1:0]  lowmask;
	logic [ADDR_W-1:0]  submask;
	logic [ADDR_W-1:0]  two_sub;
	logic [POW_W-1:0]   shift7;
	logic [5:0]         shift;
	logic [ADDR_W-1:0]  len_shift;
	logic [ADDR_W-1:0]  addr_shift;
	logic [3:0]         n_avail;
	logic [3:0]         room;
	logic [2:0]         k;
	logic [3:0]         nen;
	logic               whole;
	logic               part;
	logic               found;
	logic               done_ok;
	logic               pow_spent;
	logic               fail;
	logic [1:0]         fail_status;

	logic [15:0]           en_wide;
	logic [SUBREGIONS-1:0] dis;
	logic [ADDR_W-1:0]     step;
	logic [POW_W-1:0]      code7;
	result_t               new_res;
	result_t               final_res;
	result_t               status_res;

	logic    do_emit;
	result_t emit_res;
	logic    do_latch;
	logic    do_dec;
	logic    do_apply;
	logic    do_clear_pend;
	logic    do_set_status;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// per size step checks
	always_comb begin
		lowmask    = ~(ONES << pow_q);
		shift7     = pow_q - 7'd3;
		shift      = shift7[5:0];
		submask    = ~(ONES << shift);
		two_sub    = 64'd1 << (pow_q - 7'd2);
		len_shift  = len_q >> shift;
		addr_shift = addr_q >> shift;
		k          = addr_shift[2:0];
		n_avail    = (|len_shift[ADDR_W-1:3]) ? 4'd8 : {1'b0, len_shift[2:0]};
		room       = 4'd8 - {1'b0, k};
		nen        = (n_avail < room) ? n_avail : room;
		whole      = ((addr_q & lowmask) == '0) && ((end_q & lowmask) == '0);
		part       = !whole && ((addr_q & submask) == '0) && (len_q > two_sub);
		found      = whole || part;
		done_ok    = (len_q == '0);
		pow_spent  = (pow_q <= SMALLEST_FAIL_POW);
		fail       = !done_ok && (pow_spent || (found && (reg_q >= limit_q)));
		fail_status = pow_spent ? STATUS_NOT_COVERABLE : STATUS_OUT_OF_REGIONS;
	end

	// region build from the latched choice
	always_comb begin
		en_wide = ((16'd1 << nen_q) - 16'd1) << k_q;
		dis     = whole_q ? '0 : ~en_wide[SUBREGIONS-1:0];
		step    = whole_q ? (lowmask + 64'd1) : (ADDR_W'(nen_q) << shift);
		code7   = pow_q - 7'd1;

		new_res                   = '0;
		new_res.region_index      = reg_q[INDEX_W-1:0];
		new_res.base_address      = whole_q ? addr_q : (addr_q & ~lowmask);
		new_res.size_code         = code7[CODE_W-1:0];
		new_res.subregion_disable = dis;
		new_res.attributes_out    = attr_q;
		new_res.entry_valid       = 1'b1;

		final_res                  = pend_q;
		final_res.status           = STATUS_OK;
		final_res.next_free_region = reg_q;
		final_res.last             = 1'b1;

		status_res                  = '0;
		status_res.next_free_region = reg_q;
		status_res.last             = 1'b1;
		status_res.status           = (state_q == ST_ERR) ? status_q : STATUS_OK;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (job_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (done_ok) begin
					if (slot_free) state_d = ST_IDLE;
				end else if (fail) begin
					if (slot_free || !pend_valid_q) state_d = ST_ERR;
				end else if (found) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (slot_free || !pend_valid_q) state_d = ST_CHECK;
			end
			ST_ERR: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop           = 1'b0;
		do_emit       = 1'b0;
		emit_res      = pend_q;
		do_latch      = 1'b0;
		do_dec        = 1'b0;
		do_apply      = 1'b0;
		do_clear_pend = 1'b0;
		do_set_status = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop = job_valid;
			end
			ST_CHECK: begin
				if (done_ok) begin
					if (slot_free) begin
						do_emit       = 1'b1;
						emit_res      = pend_valid_q ? final_res : status_res;
						do_clear_pend = 1'b1;
					end
				end else if (fail) begin
					if (slot_free || !pend_valid_q) begin
						do_set_status = 1'b1;
						do_emit       = pend_valid_q;
						do_clear_pend = 1'b1;
					end
				end else if (found) begin
					do_latch = 1'b1;
				end else begin
					do_dec = 1'b1;
				end
			end
			ST_APPLY: begin
				if (slot_free || !pend_valid_q) begin
					do_apply = 1'b1;
					do_emit  = pend_valid_q;
				end
			end
			ST_ERR: begin
				if (slot_free) begin
					do_emit  = 1'b1;
					emit_res = status_res;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_apply) begin
				pend_valid_q <= 1'b1;
			end else if (do_clear_pend) begin
				pend_valid_q <= 1'b0;
			end
			if (do_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			addr_q  <= job.addr;
			len_q   <= job.len;
			end_q   <= job.end_addr;
			attr_q  <= job.attr;
			reg_q   <= {1'b0, job.first};
			top_q   <= job.top;
			limit_q <= job.limit;
			pow_q   <= job.top;
		end else if (do_dec) begin
			pow_q <= pow_q - 7'd1;
		end else if (do_apply) begin
			addr_q <= addr_q + step;
			len_q  <= len_q - step;
			reg_q  <= reg_q + 5'd1;
			pow_q  <= top_q;
		end
		if (do_latch) begin
			whole_q <= whole;
			k_q     <= k;
			nen_q   <= nen;
		end
		if (do_set_status) begin
			status_q <= fail_status;
		end
		if (do_apply) begin
			pend_q <= new_res;
		end
		if (do_emit) begin
			out_q <= emit_res;
		end
	end

endmodule

>>> rtl/core/protection_region_decomposer.sv
// top level of the protection region decomposer
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_data (request_t)
//  out     | output    | out_valid / out_ready| out_data (result_t), one or more per request
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// a request enters the queue and is then loaded into the sequencer; the sequencer tries
// sizes from the configured address width downward and builds one region per size found,
// up to the configured region count
// reset clears the state machine, the queue pointers and the output valid; config
// returns to address width 32 and region count 9
// a stalled output holds the sequencer before each result; the queue takes requests until full
module protection_region_decomposer
	import prd_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  request_t               in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output result_t                out_data,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic push;
	logic full;
	job_t push_job;
	logic pop;
	logic pop_valid;
	job_t pop_job;

	prd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.full      (full),
		.push      (push),
		.job       (push_job)
	);

	prd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_job)
	);

	prd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job       (pop_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
